/* rtl/edo_pkg.sv */
// Shared types and constants for the elevator order dispatcher.
// Used by the floor cells, the decision logic and the top level.
package edo_pkg;

  // Default number of floors and lamp field width.
  localparam int unsigned FLOORS_DEF    = 4;
  localparam int unsigned BTN_PER_FLOOR = 3;
  localparam int unsigned LAMP_W        = 12;

  // Button codes.
  localparam logic [1:0] BTN_UP   = 2'd0;
  localparam logic [1:0] BTN_DOWN = 2'd1;
  localparam logic [1:0] BTN_CAB  = 2'd2;

  // Signed direction codes.
  localparam logic signed [1:0] DIR_UP   = 2'sb01;
  localparam logic signed [1:0] DIR_STOP = 2'sb00;
  localparam logic signed [1:0] DIR_DOWN = 2'sb11;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_PRESS       = 2'd0,
    OP_CLEAR_FLOOR = 2'd1,
    OP_CLEAR_ALL   = 2'd2,
    OP_EVAL        = 2'd3
  } op_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SETTLE,
    S_RESULT
  } state_e;

  // Update command for one floor cell.
  typedef struct packed {
    logic [BTN_PER_FLOOR-1:0] set_mask;
    logic                     clear;
  } cell_cmd_t;

  // What the decision logic sees of the selected floor.
  typedef struct packed {
    logic [BTN_PER_FLOOR-1:0] bits;
    logic                     below;
    logic                     above;
  } cell_view_t;

endpackage

/* rtl/elevator_order_dispatcher.sv */
// Elevator order dispatcher: a row of floor cells with scan-style dispatch.
// After an input word is accepted, the sequencer waits in the settle state while the
// below/above summaries ripple one floor a cycle across the row, then the output
// register loads. A new word is taken only once the result word has been loaded,
// so a stalled sink also holds off the input.
// Reset clears all order bits and the output valid flag; the block is ready at once.
module elevator_order_dispatcher
  import edo_pkg::*;
#(
  parameter int unsigned FLOORS = FLOORS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] opcode, [3:2] floor, [5:4] button, [7:6] direction,
  // [9:8] between_position, [15:10] zero
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] should_stop, [2:1] next_direction, [3] queue_empty, [15:4] order_lamps
  output logic [15:0] m_axis_tdata
);

  localparam int unsigned CNT_W = $clog2(FLOORS);
  localparam int unsigned ALL_W = BTN_PER_FLOOR * FLOORS;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic              in_acc;
  op_e               in_op;
  logic [1:0]        in_floor, in_btn;
  logic [1:0]        floor_q;
  op_e               op_q;
  logic signed [1:0] dir_q, betw_q;

  cell_cmd_t                cmd   [FLOORS];
  logic [BTN_PER_FLOOR-1:0] bits  [FLOORS];
  logic                     below [FLOORS];
  logic                     above [FLOORS];
  cell_view_t               views [FLOORS];

  cell_view_t        sel_view;
  logic              in_range, any_all;
  logic              dec_stop;
  logic signed [1:0] dec_next;
  logic [ALL_W-1:0]  all_bits;
  logic [LAMP_W-1:0] lamps_c;

  logic              out_valid_q, out_load;
  logic              stop_q, empty_q;
  logic signed [1:0] next_q;
  logic [LAMP_W-1:0] lamps_q;

  // Input field decode.
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_op    = op_e'(s_axis_tdata[1:0]);
  assign in_floor = s_axis_tdata[3:2];
  assign in_btn   = s_axis_tdata[5:4];

  // Item capture for the evaluation stage.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= in_op;
      floor_q <= in_floor;
      dir_q   <= s_axis_tdata[7:6];
      betw_q  <= s_axis_tdata[9:8];
    end
  end

  // Per-floor commands; presses that make no sense at the end floors drop out.
  always_comb begin
    for (int i = 0; i < int'(FLOORS); i++) begin
      for (int b = 0; b < int'(BTN_PER_FLOOR); b++) begin
        cmd[i].set_mask[b] = in_acc && in_op == OP_PRESS &&
                             32'(in_floor) == i && 32'(in_btn) == b &&
                             !(i == 0 && b == int'(BTN_DOWN)) &&
                             !(i == int'(FLOORS) - 1 && b == int'(BTN_UP));
      end
      cmd[i].clear = in_acc && (in_op == OP_CLEAR_ALL ||
                                (in_op == OP_CLEAR_FLOOR && 32'(in_floor) == i));
    end
  end

  // The row of floor cells.
  for (genvar i = 0; i < FLOORS; i++) begin : g_cell
    logic below_in, above_in;
    if (i == 0) begin : g_bot
      assign below_in = 1'b0;
    end else begin : g_mid_b
      assign below_in = below[i-1];
    end
    if (i == FLOORS - 1) begin : g_top
      assign above_in = 1'b0;
    end else begin : g_mid_a
      assign above_in = above[i+1];
    end

    edo_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd[i]),
      .below_i (below_in),
      .above_i (above_in),
      .bits_o  (bits[i]),
      .below_o (below[i]),
      .above_o (above[i]),
      .view_o  (views[i])
    );

    assign all_bits[BTN_PER_FLOOR*i +: BTN_PER_FLOOR] = bits[i];
  end

  // Lamp field: the lowest order bits, zero above the last floor.
  for (genvar k = 0; k < LAMP_W; k++) begin : g_lamp
    if (k < ALL_W) begin : g_on
      assign lamps_c[k] = all_bits[k];
    end else begin : g_off
      assign lamps_c[k] = 1'b0;
    end
  end

  // Pick the car's floor out of the row.
  always_comb begin
    sel_view = '0;
    for (int i = 0; i < int'(FLOORS); i++) begin
      if (32'(floor_q) == i) begin
        sel_view = views[i];
      end
    end
  end

  assign in_range = 32'(floor_q) < FLOORS;
  assign any_all  = below[FLOORS-1];

  edo_decide u_decide (
    .view_i     (sel_view),
    .in_range_i (in_range),
    .any_i      (any_all),
    .dir_i      (dir_q),
    .betw_i     (betw_q),
    .stop_o     (dec_stop),
    .next_o     (dec_next)
  );

  // Sequencer next state: wait until the summaries have crossed the row.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_SETTLE;
          cnt_d   = CNT_W'(FLOORS - 1);
        end
      end
      S_SETTLE: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      S_IDLE:   s_axis_tready = 1'b1;
      S_SETTLE: ;
      S_RESULT: out_load = !out_valid_q || m_axis_tready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Output register; it holds a word until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      stop_q  <= (op_q == OP_EVAL) ? dec_stop : 1'b0;
      next_q  <= (op_q == OP_EVAL) ? dec_next : DIR_STOP;
      empty_q <= ~any_all;
      lamps_q <= lamps_c;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {lamps_q, empty_q, next_q, stop_q};

  // A new result word only comes out of the result state.
  a_load_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_RESULT)
    else $error("result word appeared outside the result state");

  // An accepted word always starts the settle wait.
  a_accept_settles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_SETTLE)
    else $error("accepted word did not enter the settle wait");

  // An empty queue shows no lamps.
  a_empty_lamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[3]) |-> m_axis_tdata[15:4] == '0)
    else $error("queue reported empty while lamps are lit");

endmodule

/* rtl/edo_cell.sv */
// One floor cell: holds the three order bits of a floor and passes
// "some order below" upward and "some order above" downward, one hop a cycle.
// Depends on edo_pkg.
module edo_cell
  import edo_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_cmd_t                cmd_i,
  input  logic                     below_i,
  input  logic                     above_i,
  output logic [BTN_PER_FLOOR-1:0] bits_o,
  output logic                     below_o,
  output logic                     above_o,
  output cell_view_t               view_o
);

  logic [BTN_PER_FLOOR-1:0] bits_q, bits_d;
  logic                     below_q, above_q;

  // Order bit update: clear wins over a press.
  always_comb begin
    if (cmd_i.clear) begin
      bits_d = '0;
    end else begin
      bits_d = bits_q | cmd_i.set_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q  <= '0;
      below_q <= 1'b0;
      above_q <= 1'b0;
    end else begin
      bits_q  <= bits_d;
      below_q <= below_i;
      above_q <= above_i;
    end
  end

  // Neighbors see this floor folded into the running summaries.
  assign bits_o  = bits_q;
  assign below_o = below_q | (|bits_q);
  assign above_o = above_q | (|bits_q);
  assign view_o  = '{bits: bits_q, below: below_q, above: above_q};

endmodule

/* rtl/edo_decide.sv */
// Stop and direction decision for the floor the car is at.
// Depends on edo_pkg; fed by the selected floor cell.
module edo_decide
  import edo_pkg::*;
(
  input  cell_view_t        view_i,
  input  logic              in_range_i,
  input  logic              any_i,
  input  logic signed [1:0] dir_i,
  input  logic signed [1:0] betw_i,
  output logic              stop_o,
  output logic signed [1:0] next_o
);

  logic any_below, any_above, same;
  logic up_call, dn_call, cab;
  logic go_down, go_up;

  // Above the top floor every order lies below the car.
  always_comb begin
    if (in_range_i) begin
      any_below = view_i.below;
      any_above = view_i.above;
      same      = |view_i.bits;
    end else begin
      any_below = any_i;
      any_above = 1'b0;
      same      = 1'b0;
    end
  end

  // Stop rule.
  always_comb begin
    up_call = view_i.bits[BTN_UP];
    dn_call = view_i.bits[BTN_DOWN];
    cab     = view_i.bits[BTN_CAB];
    stop_o  = in_range_i &&
              ((up_call && dir_i == DIR_UP) || (dn_call && dir_i == DIR_DOWN) ||
               (dir_i != DIR_UP && up_call && !any_below) ||
               (dir_i != DIR_DOWN && dn_call && !any_above) || cab);
  end

  // Scan direction: keep going the way the car moves when it can; a stopped car prefers down.
  always_comb begin
    go_down = any_below || (same && betw_i == DIR_UP);
    go_up   = any_above || (same && betw_i == DIR_DOWN);
    next_o  = DIR_STOP;
    if (dir_i != DIR_UP) begin
      if (go_down) begin
        next_o = DIR_DOWN;
      end else if (go_up) begin
        next_o = DIR_UP;
      end
    end else begin
      if (go_up) begin
        next_o = DIR_UP;
      end else if (go_down) begin
        next_o = DIR_DOWN;
      end
    end
  end

endmodule
